// File: rtl/assert_macros.svh
// assertion macros shared by the throttle rtl
// depends on nothing; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property check on the rising clock edge, off during reset
`define PSET_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("throttle assertion failed");
// overlapping implication check, off during reset
`define PSET_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("throttle implication failed");
`else
`define PSET_ASSERT(lbl, clk, rst_n, prop)
`define PSET_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pset_pkg.sv
// shared types and constants of the per-source event throttle
// depends on nothing; imported by the core
`default_nettype none

package pset_pkg;

  // default sizing
  localparam int SOURCES_DEF   = 64;
  localparam int TIME_BITS_DEF = 48;

  // register reset values
  localparam logic        ENABLE_RST     = 1'b1;
  localparam logic [31:0] AVG_LIMIT_RST  = 32'd3000000;
  localparam logic [31:0] MAX_WINDOW_RST = 32'd60000000;
  localparam logic [15:0] MIN_CALLS_RST  = 16'd250;
  localparam logic [31:0] INIT_WIN_RST   = 32'd5000000;
  localparam logic [31:0] RESET_GAP_RST  = 32'd30000000;

  // saturation limits
  localparam logic [16:0] CALL_MAX = 17'h1FFFF;
  localparam logic [31:0] U32_MAX  = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CALLS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_GAP  = 3'd5;

  // input word
  typedef struct packed {
    logic [5:0]  source_id;
    logic [47:0] timestamp;
  } pset_in_t;

  // result word
  typedef struct packed {
    logic        suppress;
    logic        report_valid;
    logic [31:0] suppressed_count;
    logic [31:0] average_gap;
    logic [31:0] window_reported;
  } pset_out_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } pset_state_t;

endpackage

`default_nettype wire

// File: rtl/pset_ram.sv
// generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module pset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/per_source_event_throttle_core.sv
// per-source event throttle: sequencer, entry table and decision logic
// depends on pset_pkg, pset_ram and assert_macros.svh
//
// usage
//   an event word (source_id, timestamp) is taken at a rising edge with start
//   high and busy low. the source picks one entry of an on-chip table; the
//   entry is read, updated and written back, and one result word follows.
//   result: an event passes the registered ram read, the read stage registers
//   and the result register, then is on out_data with out_valid high for
//   exactly one cycle. busy is high in the read and exec states, so a new event
//   waits until the last entry is written back through the one registered port.
//   the receiver cannot stall: each result must be taken in its cycle.
//   configuration: cfg_ready is always high; a register is written on any
//   edge with cfg_valid high and should only be changed while idle.
//   reset: rst_n is synchronous, active low. registers go to their defaults
//   and a clearing pass then marks every table entry invalid, one entry per
//   cycle; busy is high during the pass while configuration writes are still
//   taken.
`default_nettype none
`include "assert_macros.svh"

module per_source_event_throttle_core
  import pset_pkg::*;
#(
  parameter int SOURCES   = SOURCES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // event channel
  input  wire logic                 start,
  output logic                      busy,
  input  wire pset_in_t             in_data,
  // result channel
  output logic                      out_valid,
  output pset_out_t                 out_data,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int IDX_W = $clog2(SOURCES);

  // one table entry
  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] last_event;
    logic [TIME_BITS-1:0] last_pass;
    logic [31:0]          avg;
    logic [16:0]          calls;
    logic [31:0]          supp;
    logic [31:0]          win;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  // configuration registers
  logic        enable_r;
  logic [31:0] avg_limit_r;
  logic [31:0] max_window_r;
  logic [15:0] min_calls_r;
  logic [31:0] init_win_r;
  logic [31:0] reset_gap_r;

  // sequencer
  pset_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r;
  logic clr_last;
  logic accept;

  // ram ports
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] idx_in, wr_addr;
  entry_t           rd_ent, wr_ent;

  // pipeline registers
  logic [IDX_W-1:0]     idx_r;
  logic [TIME_BITS-1:0] t_r;
  entry_t               ent_r;
  logic [31:0]          gap_lo_r;
  logic                 reset_hit_r;
  logic                 since_lt_r;
  logic                 out_valid_r;
  pset_out_t            out_r, out_nxt;
  entry_t               upd_ent;

  // gap terms of the read stage
  logic [TIME_BITS-1:0] gap, since;

  // decision terms of the update stage
  logic [16:0] calls_inc;
  logic [32:0] avg_sum;
  logic [31:0] avg_new;
  logic [31:0] supp_inc;
  logic [31:0] win_dbl;
  logic        do_suppress;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign clr_last  = (clr_idx_r == IDX_W'(SOURCES - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= ENABLE_RST;
      avg_limit_r  <= AVG_LIMIT_RST;
      max_window_r <= MAX_WINDOW_RST;
      min_calls_r  <= MIN_CALLS_RST;
      init_win_r   <= INIT_WIN_RST;
      reset_gap_r  <= RESET_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE:     enable_r     <= cfg_data[0];
        CFG_AVG_LIMIT:  avg_limit_r  <= cfg_data;
        CFG_MAX_WINDOW: max_window_r <= cfg_data;
        CFG_MIN_CALLS:  min_calls_r  <= cfg_data[15:0];
        CFG_INIT_WIN:   init_win_r   <= cfg_data;
        CFG_RESET_GAP:  reset_gap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // source index modulo table depth by conditional subtraction
  always_comb begin
    logic [17:0] red;
    red = 18'(in_data.source_id);
    for (int k = 5; k >= 0; k--) begin
      if (red >= 18'(SOURCES << k)) begin
        red = red - 18'(SOURCES << k);
      end
    end
    idx_in = red[IDX_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy    = 1'b1;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_ent  = upd_ent;
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_ent  = '0;
      end
      ST_IDLE: begin
        busy  = 1'b0;
        rd_en = start;
      end
      ST_EXEC: wr_en = enable_r;
      default: ;
    endcase
  end

  // state and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
    end
  end

  // entry table
  pset_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SOURCES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_en   (rd_en),
    .rd_addr (idx_in),
    .rd_data (rd_ent)
  );

  // capture the event word
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx_in;
      t_r   <= TIME_BITS'(in_data.timestamp);
    end
  end

  // read stage: gaps since last event and last passed event
  assign gap   = t_r - rd_ent.last_event;
  assign since = t_r - rd_ent.last_pass;

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      ent_r       <= rd_ent;
      gap_lo_r    <= gap[31:0];
      reset_hit_r <= (gap >= TIME_BITS'(reset_gap_r));
      since_lt_r  <= (since < TIME_BITS'(rd_ent.win));
    end
  end

  // update stage: counters, running average and throttle decision
  always_comb begin
    calls_inc   = (ent_r.calls != CALL_MAX) ? ent_r.calls + 17'd1 : ent_r.calls;
    avg_sum     = {1'b0, ent_r.avg} + {1'b0, gap_lo_r};
    avg_new     = avg_sum[32:1];
    supp_inc    = (ent_r.supp != U32_MAX) ? ent_r.supp + 32'd1 : ent_r.supp;
    win_dbl     = ent_r.win[31] ? U32_MAX : {ent_r.win[30:0], 1'b0};
    do_suppress = (calls_inc > {1'b0, min_calls_r}) &&
                  (avg_new <= avg_limit_r) && since_lt_r;
  end

  // new entry contents and result word
  always_comb begin
    upd_ent = ent_r;
    out_nxt = '0;
    if (!ent_r.valid || reset_hit_r) begin
      // fresh or stale source: start over
      upd_ent.valid      = 1'b1;
      upd_ent.last_event = t_r;
      upd_ent.last_pass  = t_r;
      upd_ent.avg        = '0;
      upd_ent.calls      = ent_r.valid ? 17'd1 : 17'd0;
      upd_ent.supp       = '0;
      upd_ent.win        = init_win_r;
    end else begin
      upd_ent.calls      = calls_inc;
      upd_ent.avg        = avg_new;
      upd_ent.last_event = t_r;
      if (do_suppress) begin
        upd_ent.supp     = supp_inc;
        out_nxt.suppress = 1'b1;
      end else begin
        upd_ent.last_pass = t_r;
        upd_ent.supp      = '0;
        if (ent_r.supp != '0) begin
          out_nxt.report_valid     = 1'b1;
          out_nxt.suppressed_count = ent_r.supp;
          out_nxt.average_gap      = avg_new;
          out_nxt.window_reported  = ent_r.win;
          if (ent_r.win < max_window_r) begin
            upd_ent.win = win_dbl;
          end
        end
      end
    end
    // disabled: all-zero result, table untouched
    if (!enable_r) begin
      out_nxt = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `PSET_ASSERT_IMP(a_result_timing, clk, rst_n, out_valid, $past(start && !busy, 3))
  `PSET_ASSERT(a_no_rw_overlap, clk, rst_n, !(wr_en && rd_en))
  `PSET_ASSERT_IMP(a_suppress_no_report, clk, rst_n, out_valid && out_data.suppress,
                   !out_data.report_valid)
  `PSET_ASSERT_IMP(a_report_count, clk, rst_n, out_valid && out_data.report_valid,
                   out_data.suppressed_count != 32'd0)

endmodule

`default_nettype wire
